@@ rtl/core/qte_pkg.sv @@
// shared types, constants and helpers of the quaternion to euler core
package qte_pkg;

    localparam int QW      = 16;
    localparam int WN_W    = 17;
    localparam int PROD_W  = 33;
    localparam int SUM_W   = 36;
    localparam int OP_W    = 34;
    localparam int CX_W    = 36;
    localparam int ANG_W   = 28;
    localparam int SPS_W   = 31;
    localparam int SQ_W    = 62;
    localparam int RAD_W   = 61;
    localparam int ROOT_W  = 31;
    localparam int PL_W    = 60;
    localparam int THR_W   = 15;
    localparam int TAB_LEN = 24;
    localparam int LANES   = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int LANE_PITCH = 0;
    localparam int LANE_HEAD  = 1;
    localparam int LANE_BANK  = 2;

    localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [25:0]      HALF_PI_Q24 = 26'sd26353589;
    localparam logic signed [15:0]      PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]      HALF_PI_Q13 = 16'sd12868;
    localparam logic [THR_W-1:0]        THR_RESET   = 15'd32765;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0
    } reg_index_t;

    typedef logic [24:0] atan_entry_t;

    localparam atan_entry_t ATAN_TAB [TAB_LEN] = '{
        25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
        25'd1047214,  25'd524117,  25'd262123,  25'd131069,
        25'd65536,    25'd32768,   25'd16384,   25'd8192,
        25'd4096,     25'd2048,    25'd1024,    25'd512,
        25'd256,      25'd128,     25'd64,      25'd32,
        25'd16,       25'd8,       25'd4,       25'd2
    };

    typedef struct packed {
        logic                     lock;
        logic signed [ANG_W-1:0]  pitch_lock;
        logic signed [OP_W-1:0]   head_y;
        logic signed [OP_W-1:0]   head_x;
        logic signed [OP_W-1:0]   bank_y;
        logic signed [OP_W-1:0]   bank_x;
        logic signed [SPS_W-1:0]  sp;
    } front_side_t;

    typedef struct packed {
        logic                     lock;
        logic signed [ANG_W-1:0]  pitch_lock;
    } tail_side_t;

    // q.24 to q.13, round half away from zero, then clamp to +-lim
    function automatic logic signed [15:0] round_sat(
        input logic signed [ANG_W-1:0] a,
        input logic signed [15:0]      lim
    );
        logic signed [ANG_W:0] a_ext;
        logic signed [ANG_W:0] r;
        logic signed [ANG_W:0] lim_ext;
        a_ext   = (ANG_W+1)'(a);
        lim_ext = (ANG_W+1)'(lim);
        if (a_ext >= 0)
        begin
            r = (a_ext + 29'sd1024) >>> 11;
        end
        else
        begin
            r = -((-a_ext + 29'sd1024) >>> 11);
        end
        if (r > lim_ext)
        begin
            r = lim_ext;
        end
        else if (r < -lim_ext)
        begin
            r = -lim_ext;
        end
        return r[15:0];
    endfunction

endpackage

@@ rtl/core/qte_channels_if.sv @@
// request and result channel interfaces of the quaternion to euler core
interface qte_quat_if;
    import qte_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic signed [QW-1:0]  quat_w;
    logic signed [QW-1:0]  quat_x;
    logic signed [QW-1:0]  quat_y;
    logic signed [QW-1:0]  quat_z;

    modport source (output valid, operation, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, operation, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    import qte_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [15:0]  heading_angle;
    logic signed [14:0]  pitch_angle;
    logic signed [15:0]  bank_angle;
    logic                gimbal_lock;

    modport source (output valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                    input ready);
    modport sink (input valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                  output ready);
endinterface

@@ rtl/core/qte_front.sv @@
// products, sin(pitch), gimbal test and square root radicand
module qte_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          operation,
    input  logic signed [qte_pkg::QW-1:0] quat_w,
    input  logic signed [qte_pkg::QW-1:0] quat_x,
    input  logic signed [qte_pkg::QW-1:0] quat_y,
    input  logic signed [qte_pkg::QW-1:0] quat_z,
    input  logic [qte_pkg::THR_W-1:0]     threshold,
    output logic                          out_valid,
    output logic [qte_pkg::RAD_W-1:0]     rad,
    output qte_pkg::front_side_t          side
);
    import qte_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF = 36'sd536870912;

    // stage 1: conjugate
    logic                  v1_reg;
    logic signed [WN_W-1:0] w1_next, w1_reg;
    logic signed [QW-1:0]  x1_reg, y1_reg, z1_reg;

    assign w1_next = operation ? -WN_W'(quat_w) : WN_W'(quat_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w1_next;
            x1_reg <= quat_x;
            y1_reg <= quat_y;
            z1_reg <= quat_z;
        end
    end

    // stage 2: products
    logic v2_reg;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, xz_reg, wy_reg, xx_reg;
    logic signed [PROD_W-1:0] yy_reg, zz_reg, xy_reg, wz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= PROD_W'(w1_reg) * PROD_W'(x1_reg);
            yz_reg <= PROD_W'(y1_reg) * PROD_W'(z1_reg);
            xz_reg <= PROD_W'(x1_reg) * PROD_W'(z1_reg);
            wy_reg <= PROD_W'(w1_reg) * PROD_W'(y1_reg);
            xx_reg <= PROD_W'(x1_reg) * PROD_W'(x1_reg);
            yy_reg <= PROD_W'(y1_reg) * PROD_W'(y1_reg);
            zz_reg <= PROD_W'(z1_reg) * PROD_W'(z1_reg);
            xy_reg <= PROD_W'(x1_reg) * PROD_W'(y1_reg);
            wz_reg <= PROD_W'(w1_reg) * PROD_W'(z1_reg);
        end
    end

    // stage 3: sums and gimbal test
    logic signed [SUM_W-1:0] sp_full, sp_mag, thr_full;
    logic signed [SUM_W-1:0] hy_full, hx_full, by_full, bx_full;
    logic                    lock3_next;

    always_comb
    begin
        sp_full  = (SUM_W'(wx_reg) - SUM_W'(yz_reg)) <<< 1;
        sp_mag   = (sp_full < 0) ? -sp_full : sp_full;
        thr_full = SUM_W'({threshold, 15'b0});
        lock3_next = sp_mag > thr_full;
        if (lock3_next)
        begin
            hy_full = SUM_W'(wy_reg) - SUM_W'(xz_reg);
            hx_full = HALF - SUM_W'(yy_reg) - SUM_W'(zz_reg);
        end
        else
        begin
            hy_full = SUM_W'(xz_reg) + SUM_W'(wy_reg);
            hx_full = HALF - SUM_W'(xx_reg) - SUM_W'(yy_reg);
        end
        by_full = SUM_W'(xy_reg) + SUM_W'(wz_reg);
        bx_full = HALF - SUM_W'(xx_reg) - SUM_W'(zz_reg);
    end

    logic                   v3_reg, lock3_reg;
    logic signed [OP_W-1:0] sp3_reg, hy3_reg, hx3_reg, by3_reg, bx3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lock3_reg <= lock3_next;
            sp3_reg   <= OP_W'(sp_full);
            hy3_reg   <= OP_W'(hy_full);
            hx3_reg   <= OP_W'(hx_full);
            by3_reg   <= OP_W'(by_full);
            bx3_reg   <= OP_W'(bx_full);
        end
    end

    // stage 4: sp squared and locked pitch product
    logic signed [SPS_W-1:0] sp_lo;
    logic                    v4_reg, lock4_reg;
    logic [SQ_W-1:0]         sq4_reg;
    logic signed [PL_W-1:0]  pl4_reg;
    logic signed [SPS_W-1:0] sp4_reg;
    logic signed [OP_W-1:0]  hy4_reg, hx4_reg, by4_reg, bx4_reg;

    assign sp_lo = sp3_reg[SPS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lock4_reg <= lock3_reg;
            sq4_reg   <= SQ_W'(sp_lo) * SQ_W'(sp_lo);
            pl4_reg   <= PL_W'(sp3_reg) * PL_W'(HALF_PI_Q24);
            sp4_reg   <= sp_lo;
            hy4_reg   <= hy3_reg;
            hx4_reg   <= hx3_reg;
            by4_reg   <= by3_reg;
            bx4_reg   <= bx3_reg;
        end
    end

    // stage 5: radicand and rounding of the locked pitch
    logic [SQ_W-1:0]        rad_full;
    logic signed [PL_W:0]   pl_ext, pl_rnd;
    logic [RAD_W-1:0]       rad5_reg;
    logic                   v5_reg;
    front_side_t            side5_next, side5_reg;

    always_comb
    begin
        rad_full = (SQ_W'(1) << 60) - sq4_reg;
        pl_ext   = (PL_W+1)'(pl4_reg);
        if (pl_ext >= 0)
        begin
            pl_rnd = (pl_ext + (61'sd1 <<< 29)) >>> 30;
        end
        else
        begin
            pl_rnd = -((-pl_ext + (61'sd1 <<< 29)) >>> 30);
        end
        side5_next.lock       = lock4_reg;
        side5_next.pitch_lock = ANG_W'(pl_rnd);
        side5_next.head_y     = hy4_reg;
        side5_next.head_x     = hx4_reg;
        side5_next.bank_y     = by4_reg;
        side5_next.bank_x     = bx4_reg;
        side5_next.sp         = sp4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad5_reg  <= rad_full[RAD_W-1:0];
            side5_reg <= side5_next;
        end
    end

    assign out_valid = v5_reg;
    assign rad       = rad5_reg;
    assign side      = side5_reg;

endmodule

@@ rtl/core/qte_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module qte_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [qte_pkg::RAD_W-1:0]  rad,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       out_valid,
    output logic [qte_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          side_out
);
    import qte_pkg::*;

    localparam int TW = RAD_W + 2;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              v_reg    [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - s;

        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_s;
        logic              v_in;
        logic [TW-1:0]     trial;
        logic              take;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_s  = side_in;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_s  = side_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        assign trial     = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
        assign take      = TW'(rem_in) >= trial;
        assign rem_next  = take ? rem_in - trial[RAD_W-1:0] : rem_in;
        assign root_next = take ? (root_in | (ROOT_W'(1) << K)) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_s;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

@@ rtl/core/qte_cordic.sv @@
// three lane pipelined vectoring cordic for atan2
module qte_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [qte_pkg::OP_W-1:0]  y_in [qte_pkg::LANES],
    input  logic signed [qte_pkg::OP_W-1:0]  x_in [qte_pkg::LANES],
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic signed [qte_pkg::ANG_W-1:0] z_out [qte_pkg::LANES],
    output logic [SIDE_W-1:0]              side_out
);
    import qte_pkg::*;

    // quadrant fold
    logic signed [CX_W-1:0]  xp_reg [LANES];
    logic signed [CX_W-1:0]  yp_reg [LANES];
    logic signed [ANG_W-1:0] zp_reg [LANES];
    logic                    zerop_reg [LANES];
    logic [SIDE_W-1:0]       sidep_reg;
    logic                    vp_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_pre
        logic signed [CX_W-1:0] xe, ye;
        assign xe = CX_W'(x_in[l]);
        assign ye = CX_W'(y_in[l]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zerop_reg[l] <= (xe == 0) && (ye == 0);
                if (xe < 0)
                begin
                    xp_reg[l] <= -xe;
                    yp_reg[l] <= -ye;
                    zp_reg[l] <= (ye >= 0) ? PI_Q24 : -PI_Q24;
                end
                else
                begin
                    xp_reg[l] <= xe;
                    yp_reg[l] <= ye;
                    zp_reg[l] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sidep_reg <= side_in;
        end
    end

    // micro-rotations
    logic signed [CX_W-1:0]  x_reg    [STAGES][LANES];
    logic signed [CX_W-1:0]  y_reg    [STAGES][LANES];
    logic signed [ANG_W-1:0] z_reg    [STAGES][LANES];
    logic                    zero_reg [STAGES][LANES];
    logic [SIDE_W-1:0]       side_reg [STAGES];
    logic                    v_reg    [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam logic signed [ANG_W-1:0] ANG = ANG_W'(ATAN_TAB[s]);

        logic [SIDE_W-1:0] side_s;
        logic              v_in;

        if (s == 0)
        begin : g_first_ctl
            assign side_s = sidep_reg;
            assign v_in   = vp_reg;
        end
        else
        begin : g_rest_ctl
            assign side_s = side_reg[s-1];
            assign v_in   = v_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic signed [CX_W-1:0]  xi, yi, xs, ys;
            logic signed [ANG_W-1:0] zi;
            logic                    zri;

            if (s == 0)
            begin : g_first
                assign xi  = xp_reg[l];
                assign yi  = yp_reg[l];
                assign zi  = zp_reg[l];
                assign zri = zerop_reg[l];
            end
            else
            begin : g_rest
                assign xi  = x_reg[s-1][l];
                assign yi  = y_reg[s-1][l];
                assign zi  = z_reg[s-1][l];
                assign zri = zero_reg[s-1][l];
            end

            assign xs = xi >>> s;
            assign ys = yi >>> s;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[s][l] <= zri;
                    if (yi >= 0)
                    begin
                        x_reg[s][l] <= xi + ys;
                        y_reg[s][l] <= yi - xs;
                        z_reg[s][l] <= zi + ANG;
                    end
                    else
                    begin
                        x_reg[s][l] <= xi - ys;
                        y_reg[s][l] <= yi + xs;
                        z_reg[s][l] <= zi - ANG;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_s;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        // atan2(0, 0) is zero
        assign z_out[l] = zero_reg[STAGES-1][l] ? '0 : z_reg[STAGES-1][l];
    end

    assign out_valid = v_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ rtl/core/quaternion_to_euler_core.sv @@
// top level of the quaternion to euler angle converter
//
// quat carries one unit quaternion (w, x, y, z in q1.15) and an operation
// bit per request: 0 object-to-inertial, 1 inertial-to-object. euler returns
// heading and bank in q3.13 radians, pitch in q2.13 radians, and a gimbal
// lock flag, one result per request, in order.
// the apb port holds the gimbal threshold at byte address 0; reads return it.
// throughput is one request per cycle while euler is not stalled; the
// pipeline has the front stages of products and sums, 31 square root stages
// (one root bit each, set by the 61 bit radicand of cos(pitch)), one quadrant
// fold stage and a stage per cordic micro-rotation, and the output register.
// when euler is stalled with a result in the output register, the whole
// pipeline holds and quat.ready is low; nothing is dropped or repeated.
// reset clears all valid bits and loads the threshold with 32765.
module quaternion_to_euler_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qte_pkg::ADDR_W-1:0]     paddr,
    input  logic [qte_pkg::DATA_W-1:0]     pwdata,
    output logic [qte_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    qte_quat_if.sink                       quat,
    qte_euler_if.source                    euler
);
    import qte_pkg::*;

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic             cfg_hit;

    assign cfg_hit = paddr[ADDR_W-1:2] == REG_THRESHOLD;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv        = !out_valid_reg || euler.ready;
    assign quat.ready = adv;

    logic             f_valid;
    logic [RAD_W-1:0] f_rad;
    front_side_t      f_side;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (quat.valid),
        .operation (quat.operation),
        .quat_w    (quat.quat_w),
        .quat_x    (quat.quat_x),
        .quat_y    (quat.quat_y),
        .quat_z    (quat.quat_z),
        .threshold (thr_reg),
        .out_valid (f_valid),
        .rad       (f_rad),
        .side      (f_side)
    );

    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    front_side_t       s_side;

    qte_isqrt #(
        .SIDE_W ($bits(front_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_valid),
        .rad       (f_rad),
        .side_in   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    logic signed [OP_W-1:0]  c_y [LANES];
    logic signed [OP_W-1:0]  c_x [LANES];
    logic signed [ANG_W-1:0] c_z [LANES];
    tail_side_t              c_side_in, c_side;
    logic                    c_valid;

    assign c_y[LANE_PITCH] = OP_W'(s_side.sp);
    assign c_x[LANE_PITCH] = OP_W'(s_root);
    assign c_y[LANE_HEAD]  = s_side.head_y;
    assign c_x[LANE_HEAD]  = s_side.head_x;
    assign c_y[LANE_BANK]  = s_side.bank_y;
    assign c_x[LANE_BANK]  = s_side.bank_x;

    assign c_side_in.lock       = s_side.lock;
    assign c_side_in.pitch_lock = s_side.pitch_lock;

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(tail_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_valid),
        .y_in      (c_y),
        .x_in      (c_x),
        .side_in   (c_side_in),
        .out_valid (c_valid),
        .z_out     (c_z),
        .side_out  (c_side)
    );

    // output register
    logic signed [ANG_W-1:0] pitch24;
    logic signed [15:0]      heading_next, pitch_next, bank_next;
    logic signed [15:0]      heading_reg, bank_reg;
    logic signed [14:0]      pitch_reg;
    logic                    lock_reg;

    always_comb
    begin
        pitch24      = c_side.lock ? c_side.pitch_lock : c_z[LANE_PITCH];
        heading_next = round_sat(c_z[LANE_HEAD], PI_Q13);
        pitch_next   = round_sat(pitch24, HALF_PI_Q13);
        bank_next    = c_side.lock ? '0 : round_sat(c_z[LANE_BANK], PI_Q13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            heading_reg <= heading_next;
            pitch_reg   <= pitch_next[14:0];
            bank_reg    <= bank_next;
            lock_reg    <= c_side.lock;
        end
    end

    assign euler.valid         = out_valid_reg;
    assign euler.heading_angle = heading_reg;
    assign euler.pitch_angle   = pitch_reg;
    assign euler.bank_angle    = bank_reg;
    assign euler.gimbal_lock   = lock_reg;

    // checks
    a_lock_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && euler.gimbal_lock |-> euler.bank_angle == 16'sd0)
        else $error("bank not zero under gimbal lock");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.pitch_angle <= 15'sd12868) &&
                        (euler.pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.heading_angle <= PI_Q13) && (euler.heading_angle >= -PI_Q13))
        else $error("heading out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && !euler.ready |=> euler.valid && $stable(euler.heading_angle) &&
                                        $stable(euler.pitch_angle))
        else $error("result changed while stalled");

endmodule

@@ bench/tb.sv @@
// self-checking testbench of the quaternion to euler core with its own angle predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qte_pkg::*;

    localparam int STAGES     = 16;
    localparam int LATENCY    = STAGES + 38;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_OFF   = 400;
    localparam int PHASE_ITEMS = 385;

    localparam logic [2:0] KNOW_LOCK = 3'b001;
    localparam logic [2:0] KNOW_HEAD = 3'b010;
    localparam logic [2:0] KNOW_BANK = 3'b100;

    localparam longint PI24      = 52707179;
    localparam longint HALF_PI24 = 26353589;

    typedef struct {
        logic               operation;
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_req_t;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [14:0] pitch;
        logic signed [15:0] bank;
        logic               lock;
    } euler_t;

    typedef struct {
        quat_req_t          q;
        logic [2:0]         known;
        logic               lock;
        logic signed [15:0] heading;
        logic signed [15:0] bank;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    qte_quat_if  quat_ch ();
    qte_euler_if euler_ch ();

    quaternion_to_euler_core #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .quat(quat_ch.sink), .euler(euler_ch.source)
    );

    euler_t      pending_angles[$];
    logic [14:0] lock_threshold;
    int          errors;
    int          idle_cycles;
    int          burst_left;
    bit          hold_request;

    directed_row_t directed[] = '{
        '{'{1'b0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b1, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        // gimbal lock, pitch up and down
        '{'{1'b0, 16'sd23170, 16'sd23170, 16'sd0, 16'sd0}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b1, 16'sd23170, 16'sd23170, 16'sd0, 16'sd0}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd23170, -16'sd23170, 16'sd0, 16'sd0}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd23170, 16'sd23170}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        // non-unit, pitch saturates
        '{'{1'b0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, KNOW_LOCK | KNOW_BANK,
          1'b1, 16'sd0, 16'sd0},
        '{'{1'b0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, KNOW_LOCK,
          1'b0, 16'sd0, 16'sd0},
        // zero vector into heading and bank atan2
        '{'{1'b0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0}, KNOW_LOCK | KNOW_HEAD,
          1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384}, KNOW_LOCK | KNOW_BANK,
          1'b0, 16'sd0, 16'sd0},
        // left half plane
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd32767, 16'sd100}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b1, 16'sd0, 16'sd0, 16'sd32767, -16'sd100}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0},
        '{'{1'b0, 16'sd0, 16'sd32767, -16'sd100, 16'sd0}, KNOW_LOCK, 1'b0, 16'sd0, 16'sd0}
    };

    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(input longint vy, input longint vx);
        longint acc;
        longint xs;
        longint ys;
        longint tab [24];
        acc = 0;
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        if (vx < 0)
        begin
            acc = (vy >= 0) ? PI24 : -PI24;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < ((STAGES > 24) ? 24 : STAGES); i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0)
            begin
                vx = vx + ys;
                vy = vy - xs;
                acc = acc + tab[i];
            end
            else
            begin
                vx = vx - ys;
                vy = vy + xs;
                acc = acc - tab[i];
            end
        end
        return acc;
    endfunction

    function automatic euler_t predict_angles(input quat_req_t q, input logic [14:0] thr);
        longint w;
        longint x;
        longint y;
        longint z;
        longint sp;
        longint mag;
        longint head24;
        longint pitch24;
        longint bank24;
        longint half;
        longint unsigned c;
        euler_t e;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        half = longint'(1) << 29;
        bank24 = 0;
        if (q.operation)
        begin
            w = -w;
        end
        sp = -2 * (y * z - w * x);
        mag = (sp < 0) ? -sp : sp;
        e.lock = mag > (longint'(thr) << 15);
        if (e.lock)
        begin
            pitch24 = round_away(sp * HALF_PI24, 30);
            head24 = vector_angle(-x * z + w * y, half - y * y - z * z);
        end
        else
        begin
            c = int_sqrt((64'd1 << 60) - longint'(unsigned'(sp * sp)));
            pitch24 = vector_angle(sp, longint'(c));
            head24 = vector_angle(x * z + w * y, half - x * x - y * y);
            bank24 = vector_angle(x * y + w * z, half - x * x - z * z);
        end
        e.heading = 16'(clamp(round_away(head24, 11), 25736));
        e.pitch = 15'(clamp(round_away(pitch24, 11), 12868));
        e.bank = 16'(clamp(round_away(bank24, 11), 25736));
        return e;
    endfunction

    function automatic quat_req_t random_quat();
        quat_req_t q;
        real a [4];
        real n;
        int kind;
        int d;
        kind = $urandom_range(0, 9);
        q.operation = $urandom_range(0, 1);
        if (kind < 5)
        begin
            n = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                a[i] = $urandom_range(0, 65535) / 32768.0 - 1.0;
                n = n + a[i] * a[i];
            end
            n = $sqrt(n);
            if (n < 0.01)
            begin
                a = '{1.0, 0.0, 0.0, 0.0};
                n = 1.0;
            end
            q.w = 16'($rtoi(a[0] / n * 32767.0));
            q.x = 16'($rtoi(a[1] / n * 32767.0));
            q.y = 16'($rtoi(a[2] / n * 32767.0));
            q.z = 16'($rtoi(a[3] / n * 32767.0));
        end
        else if (kind < 8)
        begin
            // near the pitch singularity
            d = $urandom_range(0, 600);
            q.w = 16'(23170 - d);
            q.x = $urandom_range(0, 1) ? 16'(23170 - d) : -16'(23170 - d);
            q.y = 16'($signed($urandom_range(0, 400)) - 200);
            q.z = 16'($signed($urandom_range(0, 400)) - 200);
            if ($urandom_range(0, 1))
            begin
                {q.w, q.x, q.y, q.z} = {q.y, q.z, q.w, q.x};
            end
        end
        else
        begin
            q.w = 16'($urandom);
            q.x = 16'($urandom);
            q.y = 16'($urandom);
            q.z = 16'($urandom);
        end
        return q;
    endfunction

    task automatic send_quat(input quat_req_t q, input euler_t exp_e);
        @(negedge clk);
        quat_ch.valid <= 1'b1;
        quat_ch.operation <= q.operation;
        quat_ch.quat_w <= q.w;
        quat_ch.quat_x <= q.x;
        quat_ch.quat_y <= q.y;
        quat_ch.quat_z <= q.z;
        do
        begin
            @(posedge clk);
        end
        while (!(quat_ch.valid && quat_ch.ready));
        pending_angles.push_back(exp_e);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            @(negedge clk);
            quat_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6))
            begin
                @(negedge clk);
            end
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(0, 4);
        end
    endtask

    task automatic set_threshold(input logic [14:0] v);
        @(negedge clk);
        quat_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_THRESHOLD);
        pwdata <= DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[14:0] !== v)
        begin
            $display("%0t threshold readback expected %0d actual %0d", $realtime, v,
                     prdata[14:0]);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        lock_threshold = v;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // receiver stall pattern with one long hold-off on request
    initial
    begin
        int mode;
        int stretch;
        euler_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(5, 80);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    euler_ch.ready <= 1'b0;
                    repeat (HOLD_OFF)
                    begin
                        @(negedge clk);
                    end
                    hold_request = 1'b0;
                end
                case (mode)
                    0: euler_ch.ready <= 1'b1;
                    1: euler_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: euler_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        euler_t e;
        if (euler_ch.valid && euler_ch.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t unexpected result heading %0d pitch %0d bank %0d lock %0b",
                         $realtime, euler_ch.heading_angle, euler_ch.pitch_angle,
                         euler_ch.bank_angle, euler_ch.gimbal_lock);
                errors++;
            end
            else
            begin
                e = pending_angles.pop_front();
                if (euler_ch.heading_angle !== e.heading)
                begin
                    $display("%0t heading expected %0d actual %0d", $realtime, e.heading,
                             euler_ch.heading_angle);
                    errors++;
                end
                if (euler_ch.pitch_angle !== e.pitch)
                begin
                    $display("%0t pitch expected %0d actual %0d", $realtime, e.pitch,
                             euler_ch.pitch_angle);
                    errors++;
                end
                if (euler_ch.bank_angle !== e.bank)
                begin
                    $display("%0t bank expected %0d actual %0d", $realtime, e.bank,
                             euler_ch.bank_angle);
                    errors++;
                end
                if (euler_ch.gimbal_lock !== e.lock)
                begin
                    $display("%0t gimbal lock expected %0b actual %0b", $realtime, e.lock,
                             euler_ch.gimbal_lock);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        euler_t e;
        logic [14:0] thresholds [5];
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        lock_threshold = THR_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quat_ch.valid = 1'b0;
        quat_ch.operation = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        thresholds = '{15'd32767, 15'd0, 15'd16384, 15'($urandom), THR_RESET};
        repeat (11)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            e = predict_angles(directed[i].q, lock_threshold);
            if (directed[i].known & KNOW_LOCK)
            begin
                e.lock = directed[i].lock;
            end
            if (directed[i].known & KNOW_HEAD)
            begin
                e.heading = directed[i].heading;
            end
            if (directed[i].known & KNOW_BANK)
            begin
                e.bank = directed[i].bank;
            end
            send_quat(directed[i].q, e);
        end

        for (int p = 0; p < 5; p++)
        begin
            set_threshold(thresholds[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                quat_req_t q;
                if (p == 0 && n == 20)
                begin
                    hold_request = 1'b1;
                end
                q = random_quat();
                send_quat(q, predict_angles(q, lock_threshold));
            end
        end

        @(negedge clk);
        quat_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10)
        begin
            @(posedge clk);
        end
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/qte_pkg.sv
rtl/core/qte_channels_if.sv
rtl/core/qte_front.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_core.sv
bench/tb.sv
